### rtl/rbi_pkg.sv
// Shared types and constants for the ray/box intersection tester.
package rbi_pkg;

    localparam int W         = 32;
    localparam int FRAC      = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic signed [W-1:0] T_HI = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] T_LO = 32'sh8000_0000;

    typedef struct packed {
        logic signed [W-1:0] origin_x;
        logic signed [W-1:0] origin_y;
        logic signed [W-1:0] origin_z;
        logic signed [W-1:0] dir_x;
        logic signed [W-1:0] dir_y;
        logic signed [W-1:0] dir_z;
        logic signed [W-1:0] t_min;
        logic signed [W-1:0] t_max;
    } ray_t;

    typedef struct packed {
        logic                hit;
        logic signed [W-1:0] t_near;
        logic signed [W-1:0] t_far;
    } result_t;

endpackage

### rtl/ray_box_intersection.sv
// Top level of the pipelined ray versus axis-aligned box tester.
//
// Usage: load the box corners through the configuration channel (index 0..2
// lower corner x/y/z, 3..5 upper corner x/y/z, signed Q16.16; other indexes
// are ignored; cfg_ready is always high). Write only while no request is in
// flight. Present a ray on the ray port with start high; busy stays low, so
// a request is taken every cycle it is offered.
// Each request yields one result on the result port, marked by done for a
// single cycle; the latency depends on DIV_STEPS (two quotient bits per
// divider stage by default). Throughput is one ray per cycle; the six
// plane divisions run as parallel pipelined dividers, which set the depth.
// Results come out in request order. The receiver cannot stall: a result is
// gone after its done cycle. Reset clears the box to zero and drops every
// request in flight; no done pulses follow reset until new requests arrive.
module ray_box_intersection #(
    parameter int DIV_STEPS = rbi_pkg::DIV_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rbi_pkg::ray_t                 ray,
    output logic                          done,
    output rbi_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbi_pkg::W-1:0]         cfg_data
);
    import rbi_pkg::*;

    localparam int NSTG    = W / DIV_STEPS;
    localparam int DIV_LAT = NSTG + 2;
    localparam int LAT     = 1 + DIV_LAT + 4 + 2;

    logic signed [W-1:0] box_min_reg [3];
    logic signed [W-1:0] box_max_reg [3];
    logic [LAT-1:0]      vld_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                    REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                    REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                    REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                    REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                    REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Front stage: plane minus origin, magnitudes and quotient sign.
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    assign org = '{ray.origin_x, ray.origin_y, ray.origin_z};
    assign dir = '{ray.dir_x, ray.dir_y, ray.dir_z};

    ray_t          ray_a_reg;
    ray_t          ray_dly_reg [DIV_LAT];
    logic [W:0]    num_reg  [6];
    logic [W-1:0]  den_reg  [6];
    logic          neg_reg  [6];
    logic          zero_reg [6];

    for (genvar l = 0; l < 6; l++) begin : g_pre
        localparam int A = l / 2;
        logic signed [W:0] diff_next;
        logic signed [W-1:0] plane;
        assign plane     = (l % 2 == 1) ? box_max_reg[A] : box_min_reg[A];
        assign diff_next = (W+1)'(plane) - (W+1)'(org[A]);

        always_ff @(posedge clk)
        begin
            num_reg[l]  <= diff_next[W] ? $unsigned(-diff_next) : $unsigned(diff_next);
            den_reg[l]  <= dir[A][W-1] ? $unsigned(-dir[A]) : $unsigned(dir[A]);
            neg_reg[l]  <= diff_next[W] ^ dir[A][W-1];
            zero_reg[l] <= (dir[A] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        ray_a_reg      <= ray;
        ray_dly_reg[0] <= ray_a_reg;
        for (int k = 1; k < DIV_LAT; k++)
            ray_dly_reg[k] <= ray_dly_reg[k-1];
    end

    ray_t                rd;
    logic signed [W-1:0] rorg [3];
    logic signed [W-1:0] rdir [3];
    assign rd   = ray_dly_reg[DIV_LAT-1];
    assign rorg = '{rd.origin_x, rd.origin_y, rd.origin_z};
    assign rdir = '{rd.dir_x, rd.dir_y, rd.dir_z};

    logic signed [W-1:0] t_div [6];
    logic [5:0]          acc;
    logic signed [W-1:0] t_face [6];

    for (genvar l = 0; l < 6; l++) begin : g_lane
        localparam int A = l / 2;
        localparam int B = (A + 1) % 3;
        localparam int C = (A + 2) % 3;

        rbi_div #(.STEPS(DIV_STEPS)) u_div (
            .clk  (clk),
            .num  (num_reg[l]),
            .den  (den_reg[l]),
            .neg  (neg_reg[l]),
            .zero (zero_reg[l]),
            .t    (t_div[l])
        );

        rbi_face u_face (
            .clk   (clk),
            .t     (t_div[l]),
            .t_min (rd.t_min),
            .t_max (rd.t_max),
            .org_b (rorg[B]),
            .org_c (rorg[C]),
            .dir_b (rdir[B]),
            .dir_c (rdir[C]),
            .min_b (box_min_reg[B]),
            .max_b (box_max_reg[B]),
            .min_c (box_min_reg[C]),
            .max_c (box_max_reg[C]),
            .acc   (acc[l]),
            .t_out (t_face[l])
        );
    end

    rbi_reduce u_reduce (
        .clk (clk),
        .acc (acc),
        .t   (t_face),
        .res (result)
    );

    assign done = vld_reg[LAT-1];

endmodule

### rtl/rbi_div.sv
// Pipelined signed Q16.16 divider with saturation, STEPS quotient bits per stage.
module rbi_div #(
    parameter int STEPS = rbi_pkg::DIV_STEPS
) (
    input  logic                          clk,
    input  logic [rbi_pkg::W:0]           num,
    input  logic [rbi_pkg::W-1:0]         den,
    input  logic                          neg,
    input  logic                          zero,
    output logic signed [rbi_pkg::W-1:0]  t
);
    import rbi_pkg::*;

    localparam int NSTG = W / STEPS;

    logic [W-1:0] rem_reg  [NSTG+1];
    logic [W-1:0] nlo_reg  [NSTG+1];
    logic [W-1:0] q_reg    [NSTG+1];
    logic [W-1:0] den_reg  [NSTG+1];
    logic         neg_reg  [NSTG+1];
    logic         zero_reg [NSTG+1];
    logic         ovf_reg  [NSTG+1];
    logic signed [W-1:0] t_reg;

    // Quotient of 2^32 or more saturates for either sign, unless the divisor is zero.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= {{(W-FRAC-1){1'b0}}, num[W:FRAC]};
        nlo_reg[0]  <= {num[FRAC-1:0], {(W-FRAC){1'b0}}};
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        neg_reg[0]  <= neg;
        zero_reg[0] <= zero;
        ovf_reg[0]  <= ({{(W-FRAC-1){1'b0}}, num[W:FRAC]} >= den);
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic [W-1:0] rem_next;
        logic [W-1:0] nlo_next;
        logic [W-1:0] q_next;

        always_comb
        begin
            logic [W:0] tmp;
            rem_next = rem_reg[s];
            nlo_next = nlo_reg[s];
            q_next   = q_reg[s];
            for (int i = 0; i < STEPS; i++)
            begin
                tmp = {rem_next, nlo_next[W-1]};
                nlo_next = {nlo_next[W-2:0], 1'b0};
                if (tmp >= {1'b0, den_reg[s]})
                begin
                    tmp    = tmp - {1'b0, den_reg[s]};
                    q_next = {q_next[W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[W-2:0], 1'b0};
                end
                rem_next = tmp[W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= rem_next;
            nlo_reg[s+1]  <= nlo_next;
            q_reg[s+1]    <= q_next;
            den_reg[s+1]  <= den_reg[s];
            neg_reg[s+1]  <= neg_reg[s];
            zero_reg[s+1] <= zero_reg[s];
            ovf_reg[s+1]  <= ovf_reg[s];
        end
    end

    logic signed [W-1:0] t_next;
    logic [W-1:0]        q;

    always_comb
    begin
        q = q_reg[NSTG];
        if (zero_reg[NSTG])
            t_next = '0;
        else if (ovf_reg[NSTG])
            t_next = neg_reg[NSTG] ? T_LO : T_HI;
        else if (neg_reg[NSTG])
            t_next = (q > {1'b1, {(W-1){1'b0}}}) ? T_LO : $signed(-q);
        else
            t_next = q[W-1] ? T_HI : $signed(q);
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

    assign t = t_reg;

endmodule

### rtl/rbi_face.sv
// Interval check and strict face containment of the hit point for one plane.
module rbi_face (
    input  logic                          clk,
    input  logic signed [rbi_pkg::W-1:0]  t,
    input  logic signed [rbi_pkg::W-1:0]  t_min,
    input  logic signed [rbi_pkg::W-1:0]  t_max,
    input  logic signed [rbi_pkg::W-1:0]  org_b,
    input  logic signed [rbi_pkg::W-1:0]  org_c,
    input  logic signed [rbi_pkg::W-1:0]  dir_b,
    input  logic signed [rbi_pkg::W-1:0]  dir_c,
    input  logic signed [rbi_pkg::W-1:0]  min_b,
    input  logic signed [rbi_pkg::W-1:0]  max_b,
    input  logic signed [rbi_pkg::W-1:0]  min_c,
    input  logic signed [rbi_pkg::W-1:0]  max_c,
    output logic                          acc,
    output logic signed [rbi_pkg::W-1:0]  t_out
);
    import rbi_pkg::*;

    localparam int PW = 2 * W;
    localparam int QW = PW - FRAC;
    localparam int SW = QW + 1;

    // stage 1: interval and products
    logic                 ok1_reg;
    logic signed [W-1:0]  t1_reg, ob1_reg, oc1_reg;
    logic signed [PW-1:0] pb1_reg, pc1_reg;
    // stage 2: truncate toward zero
    logic                 ok2_reg;
    logic signed [W-1:0]  t2_reg, ob2_reg, oc2_reg;
    logic signed [QW-1:0] qb2_reg, qc2_reg;
    // stage 3: hit point
    logic                 ok3_reg;
    logic signed [W-1:0]  t3_reg;
    logic signed [SW-1:0] pb3_reg, pc3_reg;
    // stage 4: containment
    logic                 acc_reg;
    logic signed [W-1:0]  t4_reg;

    logic signed [PW-1:0] sb_next, sc_next;
    logic signed [SW-1:0] lo_b, hi_b, lo_c, hi_c;

    always_comb
    begin
        sb_next = pb1_reg + (pb1_reg[PW-1] ? PW'(65535) : PW'(0));
        sc_next = pc1_reg + (pc1_reg[PW-1] ? PW'(65535) : PW'(0));
        lo_b = SW'(min_b);
        hi_b = SW'(max_b);
        lo_c = SW'(min_c);
        hi_c = SW'(max_c);
    end

    always_ff @(posedge clk)
    begin
        ok1_reg <= (t >= t_min) && (t <= t_max);
        t1_reg  <= t;
        ob1_reg <= org_b;
        oc1_reg <= org_c;
        pb1_reg <= PW'(t) * PW'(dir_b);
        pc1_reg <= PW'(t) * PW'(dir_c);

        ok2_reg <= ok1_reg;
        t2_reg  <= t1_reg;
        ob2_reg <= ob1_reg;
        oc2_reg <= oc1_reg;
        qb2_reg <= sb_next[PW-1:FRAC];
        qc2_reg <= sc_next[PW-1:FRAC];

        ok3_reg <= ok2_reg;
        t3_reg  <= t2_reg;
        pb3_reg <= SW'(ob2_reg) + SW'(qb2_reg);
        pc3_reg <= SW'(oc2_reg) + SW'(qc2_reg);

        acc_reg <= ok3_reg && (pb3_reg > lo_b) && (pb3_reg < hi_b)
                   && (pc3_reg > lo_c) && (pc3_reg < hi_c);
        t4_reg  <= t3_reg;
    end

    assign acc   = acc_reg;
    assign t_out = t4_reg;

endmodule

### rtl/rbi_reduce.sv
// Two-level registered min/max merge of the six plane crossings.
module rbi_reduce (
    input  logic                          clk,
    input  logic [5:0]                    acc,
    input  logic signed [rbi_pkg::W-1:0]  t [6],
    output rbi_pkg::result_t              res
);
    import rbi_pkg::*;

    logic                hit1_reg  [3];
    logic signed [W-1:0] near1_reg [3];
    logic signed [W-1:0] far1_reg  [3];
    result_t             res_reg;
    result_t             res_next;

    for (genvar p = 0; p < 3; p++) begin : g_pair
        logic                a, b;
        logic signed [W-1:0] ta, tb;
        assign a  = acc[2*p];
        assign b  = acc[2*p+1];
        assign ta = t[2*p];
        assign tb = t[2*p+1];

        always_ff @(posedge clk)
        begin
            hit1_reg[p]  <= a | b;
            near1_reg[p] <= (a && (!b || ta < tb)) ? ta : tb;
            far1_reg[p]  <= (a && (!b || ta > tb)) ? ta : tb;
        end
    end

    always_comb
    begin
        logic                h;
        logic signed [W-1:0] n, f;
        h = 1'b0;
        n = '0;
        f = '0;
        for (int p = 0; p < 3; p++)
        begin
            if (hit1_reg[p])
            begin
                if (!h || near1_reg[p] < n)
                    n = near1_reg[p];
                if (!h || far1_reg[p] > f)
                    f = far1_reg[p];
                h = 1'b1;
            end
        end
        res_next.hit    = h;
        res_next.t_near = n;
        res_next.t_far  = f;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
